// ===== hw/rtl/cdq_pkg.sv =====
// Shared types, constants and index helpers for the circular deque.
`default_nettype none
package cdq_pkg;

	localparam int DEPTH = 1024;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_W = 11;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 2;

	localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024) > CAP_MAX ? CAP_MAX : CAP_W'(1024);

	localparam logic [ADDR_W-1:0] REG_CAPACITY = ADDR_W'(0);

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_REAR = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT = 3'd2;
	localparam logic [2:0] ACT_POP_REAR = 3'd3;
	localparam logic [2:0] ACT_REPORT = 3'd4;

	typedef struct packed {
		logic [2:0] action;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic success;
		logic signed [DATA_W-1:0] front_value;
		logic signed [DATA_W-1:0] rear_value;
		logic is_empty;
		logic is_full;
	} out_t;

	// Advance an index by one, wrapping at the capacity in use.
	function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] n;
		n = CAP_W'(i) + CAP_W'(1);
		return (n >= cap) ? '0 : n[IDX_W-1:0];
	endfunction

	// Move an index back by one, wrapping to the last slot in use.
	function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
			input logic [CAP_W-1:0] cap);
		logic [CAP_W-1:0] m;
		m = cap - CAP_W'(1);
		return (i == '0) ? m[IDX_W-1:0] : i - IDX_W'(1);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cdq_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module cdq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_cfg.sv =====
// APB register block holding the capacity in use.
`default_nettype none
module cdq_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [cdq_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic deque_empty,
	output logic [cdq_pkg::CAP_W-1:0] capacity
);

	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [cdq_pkg::CAP_W-1:0] wr_cap;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && (paddr == cdq_pkg::REG_CAPACITY);

	// Clamp the low CAP_W bits of the written value into 1..DEPTH.
	always_comb begin
		wr_cap = pwdata[cdq_pkg::CAP_W-1:0];
		if (wr_cap == '0) begin
			wr_cap = cdq_pkg::CAP_W'(1);
		end else if (wr_cap > cdq_pkg::CAP_MAX) begin
			wr_cap = cdq_pkg::CAP_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cdq_pkg::CAP_RESET;
		end else if (wr_en && deque_empty) begin
			cap_q <= wr_cap;
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == cdq_pkg::REG_CAPACITY) begin
			prdata = 32'(cap_q);
		end
	end

	assign capacity = cap_q;

endmodule
`default_nettype wire

// ===== hw/rtl/cdq_core.sv =====
// Deque control: ends, flags, slot reads and writes, result register.
`default_nettype none
module cdq_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cdq_pkg::in_t item,
	output logic done,
	output cdq_pkg::out_t result,
	input wire logic [cdq_pkg::CAP_W-1:0] capacity,
	output logic deque_empty
);

	localparam int IW = cdq_pkg::IDX_W;
	localparam int DW = cdq_pkg::DATA_W;

	logic [IW-1:0] head_q, tail_q;
	logic empty_q;
	logic [DW-1:0] front_q, rear_q;
	logic busy_s1;
	cdq_pkg::in_t item_s1;
	logic done_q;
	cdq_pkg::out_t result_q;

	logic accept;
	logic rd_en;
	logic [IW-1:0] rd_addr;
	logic [DW-1:0] rd_data;

	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] head_d, tail_d;
	logic empty_d, full_now, full_d, ok_d;
	logic [DW-1:0] front_d, rear_d;

	assign accept = start && !busy_s1;
	assign busy = busy_s1;
	assign deque_empty = empty_q;

	// Fetch the slot that becomes the new end on a pop.
	assign rd_en = accept;
	assign rd_addr = (item.action == cdq_pkg::ACT_POP_FRONT) ?
		cdq_pkg::step_up(head_q, capacity) : cdq_pkg::step_down(tail_q, capacity);

	cdq_ram #(
		.DEPTH(cdq_pkg::DEPTH),
		.WIDTH(DW)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(item_s1.value),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign full_now = !empty_q && (head_q == cdq_pkg::step_up(tail_q, capacity));

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		empty_d = empty_q;
		front_d = front_q;
		rear_d = rear_q;
		wr_en = 1'b0;
		wr_addr = '0;
		ok_d = 1'b0;
		case (item_s1.action)
			cdq_pkg::ACT_PUSH_FRONT, cdq_pkg::ACT_PUSH_REAR: begin
				if (empty_q) begin
					head_d = '0;
					tail_d = '0;
					empty_d = 1'b0;
					front_d = item_s1.value;
					rear_d = item_s1.value;
					wr_en = 1'b1;
					wr_addr = '0;
					ok_d = 1'b1;
				end else if (!full_now) begin
					wr_en = 1'b1;
					ok_d = 1'b1;
					if (item_s1.action == cdq_pkg::ACT_PUSH_FRONT) begin
						head_d = cdq_pkg::step_down(head_q, capacity);
						wr_addr = head_d;
						front_d = item_s1.value;
					end else begin
						tail_d = cdq_pkg::step_up(tail_q, capacity);
						wr_addr = tail_d;
						rear_d = item_s1.value;
					end
				end
			end
			cdq_pkg::ACT_POP_FRONT, cdq_pkg::ACT_POP_REAR: begin
				if (!empty_q) begin
					ok_d = 1'b1;
					if (head_q == tail_q) begin
						head_d = '0;
						tail_d = '0;
						empty_d = 1'b1;
					end else if (item_s1.action == cdq_pkg::ACT_POP_FRONT) begin
						head_d = cdq_pkg::step_up(head_q, capacity);
						front_d = rd_data;
					end else begin
						tail_d = cdq_pkg::step_down(tail_q, capacity);
						rear_d = rd_data;
					end
				end
			end
			cdq_pkg::ACT_REPORT: begin
				ok_d = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		full_d = !empty_d && (head_d == cdq_pkg::step_up(tail_d, capacity));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			done_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			empty_q <= 1'b1;
		end else begin
			busy_s1 <= accept;
			done_q <= busy_s1;
			if (busy_s1) begin
				head_q <= head_d;
				tail_q <= tail_d;
				empty_q <= empty_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (busy_s1) begin
			front_q <= front_d;
			rear_q <= rear_d;
			result_q.success <= ok_d;
			result_q.front_value <= empty_d ? '1 : front_d;
			result_q.rear_value <= empty_d ? '1 : rear_d;
			result_q.is_empty <= empty_d;
			result_q.is_full <= full_d;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== hw/rtl/circular_deque_top.sv =====
// Circular deque: top level joining the register block and the deque core.
//
// Usage:
//   Command channel: drive item (action, value) with start high; the item is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for one cycle with result (success, front and
//   rear values, empty and full flags). The receiver cannot hold it off.
//   Order: the accepting edge sets busy, and the edge that ends the busy cycle
//   raises done and registers the result.
//   A new item is not taken while busy is high. The accepting edge also reads the
//   slot next to the end being popped from the synchronous slot RAM; the cycle
//   after it updates the ends, writes pushed values and registers the result.
//   busy is high during that update cycle, so the next item may be taken at
//   the edge that closes the cycle in which the previous result is shown.
//   Configuration: APB write of capacity_in_use at address 0, applied only
//   while the deque is empty; the low CAP_W bits are clamped to 1..DEPTH.
//   Reset: the deque is empty, both ends are at slot 0 and the capacity is
//   the full depth. Slot contents are not cleared; data read from empty slots is never used.
`default_nettype none
module circular_deque_top (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire cdq_pkg::in_t item,
	output logic done,
	output cdq_pkg::out_t result,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [cdq_pkg::ADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [cdq_pkg::CAP_W-1:0] capacity;
	logic deque_empty;

	cdq_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.deque_empty(deque_empty),
		.capacity(capacity)
	);

	cdq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.capacity(capacity),
		.deque_empty(deque_empty)
	);

endmodule
`default_nettype wire
